@@ rtl/sha1_stream_hasher_macros.svh @@
// Assertion macros used by the checker file.
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSH_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/ssh_pkg.sv @@
package ssh_pkg;

  localparam int unsigned NUM_WORDS  = 5;
  localparam int unsigned NUM_ROUNDS = 80;

  localparam logic [31:0] INIT_CHAIN [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_CH     = 32'h5A827999;
  localparam logic [31:0] K_PAR_LO = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ    = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR_HI = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [2:0] LAST_WORD = 3'd4;
  localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);

  typedef enum logic [1:0] {
    PH_CH     = 2'd0,
    PH_PAR_LO = 2'd1,
    PH_MAJ    = 2'd2,
    PH_PAR_HI = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SRC_INPUT  = 2'd0,
    SRC_MARK   = 2'd1,
    SRC_ZERO   = 2'd2,
    SRC_LENGTH = 2'd3
  } byte_src_t;

  typedef struct packed {
    logic      shift;
    byte_src_t src;
    logic      count_bits;
    logic      load_work;
    logic      do_round;
    phase_t    phase;
    logic      fold;
    logic      init_msg;
    logic [2:0] word_sel;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } status_t;

endpackage

@@ rtl/ssh_datapath.sv @@
module ssh_datapath
  import ssh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [7:0]  byte_in,
  output status_t     status,
  output logic [31:0] digest_word
);

  logic [511:0] blk;
  logic [31:0]  h [NUM_WORDS];
  logic [31:0]  wa, wb, wc, wd, we;
  logic [5:0]   fill;
  logic [63:0]  msg_bits;

  logic [63:0]  len_shift;
  logic [7:0]   byte_sel;
  logic [31:0]  f_val;
  logic [31:0]  k_val;
  logic [31:0]  sched_x;
  logic [31:0]  w_new;
  logic [31:0]  tmp;

  assign len_shift = msg_bits >> {~fill[2:0], 3'b000};
  assign sched_x   = blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ blk[511:480];
  assign w_new     = {sched_x[30:0], sched_x[31]};

  always_comb begin
    unique case (cmd.src)
      SRC_INPUT:  byte_sel = byte_in;
      SRC_MARK:   byte_sel = PAD_MARK;
      SRC_ZERO:   byte_sel = 8'h00;
      SRC_LENGTH: byte_sel = len_shift[7:0];
      default:    byte_sel = 8'h00;
    endcase
  end

  always_comb begin
    unique case (cmd.phase)
      PH_CH: begin
        f_val = (wb & wc) | (~wb & wd);
        k_val = K_CH;
      end
      PH_PAR_LO: begin
        f_val = wb ^ wc ^ wd;
        k_val = K_PAR_LO;
      end
      PH_MAJ: begin
        f_val = (wb & wc) | (wb & wd) | (wc & wd);
        k_val = K_MAJ;
      end
      PH_PAR_HI: begin
        f_val = wb ^ wc ^ wd;
        k_val = K_PAR_HI;
      end
      default: begin
        f_val = wb ^ wc ^ wd;
        k_val = K_PAR_HI;
      end
    endcase
  end

  assign tmp = {wa[26:0], wa[31:27]} + f_val + we + k_val + blk[511:480];

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      blk <= {blk[503:0], byte_sel};
    end else if (cmd.do_round) begin
      blk <= {blk[479:0], w_new};
    end
    if (cmd.load_work) begin
      wa <= h[0];
      wb <= h[1];
      wc <= h[2];
      wd <= h[3];
      we <= h[4];
    end else if (cmd.do_round) begin
      wa <= tmp;
      wb <= wa;
      wc <= {wb[1:0], wb[31:2]};
      wd <= wc;
      we <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init_msg) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        h[i] <= INIT_CHAIN[i];
      end
      fill     <= '0;
      msg_bits <= '0;
    end else begin
      if (cmd.fold) begin
        h[0] <= h[0] + wa;
        h[1] <= h[1] + wb;
        h[2] <= h[2] + wc;
        h[3] <= h[3] + wd;
        h[4] <= h[4] + we;
      end
      if (cmd.shift) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count_bits) begin
        msg_bits <= msg_bits + 64'd8;
      end
    end
  end

  assign status.fill = fill;
  assign digest_word = h[cmd.word_sel];

endmodule

@@ rtl/ssh_ctrl.sv @@
module ssh_ctrl
  import ssh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    has_byte,
  input  logic    end_msg,
  input  logic    out_ready,
  input  status_t status,
  output logic    in_ready,
  output logic    out_valid,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_FOLD  = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [6:0] rnd, rnd_next;
  logic [2:0] word, word_next;
  logic       ending, ending_next;
  logic       marked, marked_next;
  logic       len_ok, len_ok_next;
  logic       final_blk, final_blk_next;

  logic fill_full;
  logic fill_tail;

  assign fill_full = (status.fill == 6'd63);
  assign fill_tail = (status.fill[5:3] == 3'b111);

  always_comb begin
    state_next     = state;
    rnd_next       = rnd;
    word_next      = word;
    ending_next    = ending;
    marked_next    = marked;
    len_ok_next    = len_ok;
    final_blk_next = final_blk;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd            = '0;
    cmd.word_sel   = word;

    if (rnd < 7'd20) begin
      cmd.phase = PH_CH;
    end else if (rnd < 7'd40) begin
      cmd.phase = PH_PAR_LO;
    end else if (rnd < 7'd60) begin
      cmd.phase = PH_MAJ;
    end else begin
      cmd.phase = PH_PAR_HI;
    end

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (has_byte) begin
            cmd.shift      = 1'b1;
            cmd.src        = SRC_INPUT;
            cmd.count_bits = 1'b1;
          end
          if (has_byte && fill_full) begin
            cmd.load_work = 1'b1;
            rnd_next      = '0;
            ending_next   = end_msg;
            state_next    = ST_ROUND;
          end else if (end_msg) begin
            ending_next = 1'b1;
            state_next  = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        if (rnd == LAST_ROUND) begin
          state_next = ST_FOLD;
        end else begin
          rnd_next = rnd + 7'd1;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (final_blk) begin
          word_next  = '0;
          state_next = ST_EMIT;
        end else if (ending) begin
          len_ok_next = marked;
          state_next  = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        cmd.shift = 1'b1;
        if (!marked) begin
          cmd.src     = SRC_MARK;
          marked_next = 1'b1;
          len_ok_next = !fill_tail;
        end else if (!fill_tail || !len_ok) begin
          cmd.src = SRC_ZERO;
        end else begin
          cmd.src = SRC_LENGTH;
        end
        if (fill_full) begin
          cmd.load_work  = 1'b1;
          rnd_next       = '0;
          final_blk_next = marked && len_ok;
          state_next     = ST_ROUND;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (word == LAST_WORD) begin
            cmd.init_msg   = 1'b1;
            ending_next    = 1'b0;
            marked_next    = 1'b0;
            len_ok_next    = 1'b0;
            final_blk_next = 1'b0;
            word_next      = '0;
            state_next     = ST_IDLE;
          end else begin
            word_next = word + 3'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      word      <= '0;
      ending    <= 1'b0;
      marked    <= 1'b0;
      len_ok    <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      word      <= word_next;
      ending    <= ending_next;
      marked    <= marked_next;
      len_ok    <= len_ok_next;
      final_blk <= final_blk_next;
    end
  end

endmodule

@@ rtl/sha1_stream_hasher.sv @@
// SHA-1 hasher that takes a message at most one byte per input transfer and
// returns the 160-bit digest as five output transfers, H0 first, with tlast on
// the fifth. The transfer that completes a 64-byte block is followed by a phase
// in which the single round unit runs the 80 rounds and folds the result into
// the chaining words, and no input is taken then. The transfer that ends a
// message is followed by padding that shifts one byte per cycle into the block
// register (paused while a full block is compressed), one or two compressions,
// and the five digest transfers, after which the block is ready for the next
// message. Input is taken only while no digest is pending.
module sha1_stream_hasher
  import ssh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic [0:0]  s_tuser,   // [0] has_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast
);

  cmd_t    cmd;
  status_t status;

  ssh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .has_byte  (s_tuser[0]),
    .end_msg   (s_tlast),
    .out_ready (m_tready),
    .status    (status),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .cmd       (cmd)
  );

  ssh_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .byte_in     (s_tdata),
    .status      (status),
    .digest_word (m_tdata)
  );

  assign m_tuser = cmd.word_sel;
  assign m_tlast = (cmd.word_sel == LAST_WORD);

endmodule

@@ rtl/ssh_checker.sv @@
`include "sha1_stream_hasher_macros.svh"

module ssh_checker
  import ssh_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  logic       in_xfer;
  logic       out_xfer;
  logic       is_last;
  logic [2:0] next_index;

  assign in_xfer    = s_tvalid && s_tready;
  assign out_xfer   = m_tvalid && m_tready;
  assign is_last    = (m_tuser == LAST_WORD);
  assign next_index = m_tuser + 3'd1;

  `SSH_ASSERT_SAME(a_no_input_during_digest, clk, rst, m_tvalid, !s_tready)
  `SSH_ASSERT_SAME(a_last_on_fifth, clk, rst, m_tvalid, m_tlast == is_last)
  `SSH_ASSERT_NEXT(a_word_advances, clk, rst, out_xfer && !m_tlast, m_tuser == $past(next_index))
  `SSH_ASSERT_NEXT(a_digest_needs_end, clk, rst, in_xfer && !s_tlast, !m_tvalid)
  `SSH_ASSERT_NEXT(a_stall_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind sha1_stream_hasher ssh_checker u_ssh_checker (.*);

@@ dv/tb.sv @@
module tb;
  import ssh_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_ITEMS = 85;
  localparam int unsigned RANDOM_MESSAGES = 3;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  logic [31:0] hash_chain [NUM_WORDS];
  logic [7:0]  hash_block [64];
  int unsigned hash_fill;
  logic [63:0] hash_bits;
  digest_word_t digest_q [$];

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned hold_cycles = 0;
  int unsigned ready_left = 0;
  int unsigned ready_mode = 0;
  logic [7:0]  ready_mask = 8'hFF;
  int unsigned messages_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned items_sent = 0;
  int unsigned words_checked = 0;

  sha1_stream_hasher u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  function automatic void restart_hash();
    for (int i = 0; i < NUM_WORDS; i++) hash_chain[i] = INIT_CHAIN[i];
    hash_fill = 0;
    hash_bits = '0;
  endfunction

  function automatic void compress_hash_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, x, sum;
    for (int t = 0; t < 16; t++) begin
      w[t] = {hash_block[4*t], hash_block[4*t+1], hash_block[4*t+2], hash_block[4*t+3]};
    end
    for (int t = 16; t < 80; t++) begin
      x = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
      w[t] = {x[30:0], x[31]};
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int t = 0; t < NUM_ROUNDS; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K_PAR_LO;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_PAR_HI;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + w[t];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  function automatic void predict_digest(logic [7:0] value, logic has_byte, logic eom);
    digest_word_t dw;
    if (has_byte) begin
      hash_block[hash_fill] = value;
      hash_fill++;
      hash_bits += 64'd8;
      if (hash_fill == 64) begin
        compress_hash_block();
        hash_fill = 0;
      end
    end
    if (eom) begin
      hash_block[hash_fill] = PAD_MARK;
      hash_fill++;
      if (hash_fill > 56) begin
        while (hash_fill < 64) begin
          hash_block[hash_fill] = 8'h00;
          hash_fill++;
        end
        compress_hash_block();
        hash_fill = 0;
      end
      while (hash_fill < 56) begin
        hash_block[hash_fill] = 8'h00;
        hash_fill++;
      end
      for (int i = 0; i < 8; i++) hash_block[56+i] = hash_bits[63-8*i -: 8];
      compress_hash_block();
      for (int i = 0; i < NUM_WORDS; i++) begin
        dw.word = hash_chain[i];
        dw.index = 3'(i);
        dw.last = (3'(i) == LAST_WORD);
        digest_q = {digest_q, dw};
      end
      restart_hash();
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_item(logic [7:0] value, logic has_byte, logic eom);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tuser <= has_byte;
    s_tlast <= eom;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_digest(value, has_byte, eom);
    if (has_byte) bytes_sent++;
    items_sent++;
    if (eom) messages_sent++;
  endtask

  task automatic send_message(int unsigned len, bit end_on_byte, int unsigned noise_pct);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_empty_message();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_short_messages();
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'hFE, 1'b1, 1'b1);
  endtask

  task automatic test_receiver_holdoff();
    hold_cycles = HOLD_OFF_CYCLES;
    send_message(20, 1'b1, 0);
    send_message(5, 1'b1, 0);
    send_message(3, 1'b0, 0);
  endtask

  task automatic test_random_messages();
    int unsigned start_items;
    int unsigned start_messages;
    int unsigned len;
    int unsigned edge_lengths [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    start_items = items_sent;
    start_messages = messages_sent;
    while (items_sent - start_items < RANDOM_ITEMS ||
           messages_sent - start_messages < RANDOM_MESSAGES) begin
      if ($urandom_range(0, 99) < 20) len = edge_lengths[$urandom_range(0, 7)];
      else len = $urandom_range(0, 15);
      send_message(len, $urandom_range(0, 3) != 0, 10);
    end
    s_tvalid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else begin
      if (ready_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        ready_mask = 8'($urandom) | 8'h01;
        ready_left = $urandom_range(16, 64);
      end
      ready_left--;
      case (ready_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= ready_mask[ready_left % 8];
        end
        default: begin
          m_tready <= ($urandom_range(0, 4) == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest word", m_tdata, 32'h0);
      end else begin
        want = digest_q.pop_front();
        if (m_tdata !== want.word) report_mismatch("digest word", m_tdata, want.word);
        if (m_tuser !== want.index) report_mismatch("word index", 32'(m_tuser), 32'(want.index));
        if (m_tlast !== want.last) report_mismatch("last flag", 32'(m_tlast), 32'(want.last));
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    restart_hash();
    for (int i = 0; i < 64; i++) hash_block[i] = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_message();
    test_short_messages();
    test_receiver_holdoff();
    test_random_messages();
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Hashed %0d messages with %0d bytes in %0d transfers; %0d digest words checked.",
             messages_sent, bytes_sent, items_sent, words_checked);
    $display("Covered empty messages, idle items, random lengths and a long output hold-off.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
